### src/brd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brd_pkg
// Shared types and constants of the record stream deframer.
// ----------------------------------------------------------------------------
package brd_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned LenW    = 16;
	localparam int unsigned HdrIdxW = 3;
	localparam int unsigned StatusW = 3;

	localparam logic [HdrIdxW-1:0] HdrLast = 3'd4;
	localparam logic [ByteW-1:0]   TypeData = 8'h00;
	localparam logic [ByteW-1:0]   TypeEnd  = 8'hff;

	localparam logic CmdByte = 1'b0;
	localparam logic CmdEnd  = 1'b1;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_STOPPED = 2'd2
	} phase_t;

	typedef enum logic [StatusW-1:0] {
		ST_RUNNING   = 3'd0,
		ST_CLEAN     = 3'd1,
		ST_MALFORMED = 3'd2,
		ST_BADTYPE   = 3'd3,
		ST_SHORTHDR  = 3'd4,
		ST_SHORTPAY  = 3'd5
	} status_t;

	localparam logic [HdrIdxW-1:0] HdrType   = 3'd0;
	localparam logic [HdrIdxW-1:0] HdrLenHi  = 3'd1;
	localparam logic [HdrIdxW-1:0] HdrLenLo  = 3'd2;

endpackage
`default_nettype wire

### src/brd_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brd_in_if
// Input channel: one stream word or an end-of-input marker per handshake.
// ----------------------------------------------------------------------------
interface brd_in_if;
	logic                        valid;
	logic                        ready;
	logic                        command;
	logic [brd_pkg::ByteW-1:0]   data_byte;

	modport source(output valid, output command, output data_byte, input ready);
	modport sink(input valid, input command, input data_byte, output ready);
endinterface
`default_nettype wire

### src/brd_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brd_out_if
// Output channel: one result word per accepted input word.
// ----------------------------------------------------------------------------
interface brd_out_if;
	logic                        valid;
	logic                        ready;
	logic [brd_pkg::ByteW-1:0]   payload_byte;
	logic                        payload_valid;
	logic [brd_pkg::StatusW-1:0] parse_status;

	modport source(output valid, output payload_byte, output payload_valid,
		output parse_status, input ready);
	modport sink(input valid, input payload_byte, input payload_valid,
		input parse_status, output ready);
endinterface
`default_nettype wire

### src/binary_record_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_record_deframer
// Type / length / address record deframer, one stream word per cycle while
// the output is not stalled. The result word is registered as the input word is accepted.
// Throughput: one word per cycle while dout.ready is high; the output register frees as it is taken.
// Reset: arst_n clears parser state to header phase, status running,
// and empties the output register.
// ----------------------------------------------------------------------------
module binary_record_deframer (
	input  wire logic     clk,
	input  wire logic     arst_n,
	brd_in_if.sink        din,
	brd_out_if.source     dout
);

	brd_pkg::phase_t                  phase_q, phase_d;
	logic [brd_pkg::HdrIdxW-1:0]      hdr_idx_q, hdr_idx_d;
	logic [brd_pkg::ByteW-1:0]        rec_type_q, rec_type_d;
	logic [brd_pkg::LenW-1:0]         len_q, len_d;
	logic [brd_pkg::LenW-1:0]         remain_q, remain_d;
	brd_pkg::status_t                 status_q, status_d;

	logic                             out_valid_q;
	logic [brd_pkg::ByteW-1:0]        out_byte_q;
	logic                             out_pv_q;
	logic [brd_pkg::StatusW-1:0]      out_status_q;

	logic                             accept;
	logic [brd_pkg::ByteW-1:0]        pay_byte;
	logic                             pay_valid;
	logic [brd_pkg::LenW-1:0]         remain_dec;

	assign din.ready = !out_valid_q || dout.ready;
	assign accept    = din.valid && din.ready;
	assign remain_dec = remain_q - brd_pkg::LenW'(1);

	// next state
	always_comb begin
		phase_d    = phase_q;
		hdr_idx_d  = hdr_idx_q;
		rec_type_d = rec_type_q;
		len_d      = len_q;
		remain_d   = remain_q;
		status_d   = status_q;
		unique case (phase_q)
			brd_pkg::PH_HEADER: begin
				if (din.command == brd_pkg::CmdEnd) begin
					status_d = brd_pkg::ST_SHORTHDR;
					phase_d  = brd_pkg::PH_STOPPED;
				end else begin
					if (hdr_idx_q == brd_pkg::HdrType)
						rec_type_d = din.data_byte;
					if (hdr_idx_q == brd_pkg::HdrLenHi)
						len_d = {din.data_byte, len_q[brd_pkg::ByteW-1:0]};
					if (hdr_idx_q == brd_pkg::HdrLenLo)
						len_d = {len_q[brd_pkg::LenW-1:brd_pkg::ByteW], din.data_byte};
					if (hdr_idx_q != brd_pkg::HdrLast) begin
						hdr_idx_d = hdr_idx_q + brd_pkg::HdrIdxW'(1);
					end else begin
						hdr_idx_d = '0;
						if (rec_type_q == brd_pkg::TypeData) begin
							if (len_q != '0) begin
								remain_d = len_q;
								phase_d  = brd_pkg::PH_PAYLOAD;
							end
						end else if (rec_type_q == brd_pkg::TypeEnd) begin
							status_d = (len_q != '0) ? brd_pkg::ST_MALFORMED
								: brd_pkg::ST_CLEAN;
							phase_d  = brd_pkg::PH_STOPPED;
						end else begin
							status_d = brd_pkg::ST_BADTYPE;
							phase_d  = brd_pkg::PH_STOPPED;
						end
					end
				end
			end
			brd_pkg::PH_PAYLOAD: begin
				if (din.command == brd_pkg::CmdEnd) begin
					status_d = brd_pkg::ST_SHORTPAY;
					phase_d  = brd_pkg::PH_STOPPED;
				end else begin
					remain_d = remain_dec;
					if (remain_dec == '0)
						phase_d = brd_pkg::PH_HEADER;
				end
			end
			default: begin
			end
		endcase
	end

	// outputs
	always_comb begin
		pay_valid = (phase_q == brd_pkg::PH_PAYLOAD) && (din.command == brd_pkg::CmdByte);
		pay_byte  = pay_valid ? din.data_byte : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= brd_pkg::PH_HEADER;
			hdr_idx_q  <= '0;
			rec_type_q <= '0;
			len_q      <= '0;
			remain_q   <= '0;
			status_q   <= brd_pkg::ST_RUNNING;
		end else if (accept) begin
			phase_q    <= phase_d;
			hdr_idx_q  <= hdr_idx_d;
			rec_type_q <= rec_type_d;
			len_q      <= len_d;
			remain_q   <= remain_d;
			status_q   <= status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_byte_q   <= pay_byte;
			out_pv_q     <= pay_valid;
			out_status_q <= status_d;
		end
	end

	assign dout.valid         = out_valid_q;
	assign dout.payload_byte  = out_byte_q;
	assign dout.payload_valid = out_pv_q;
	assign dout.parse_status  = out_status_q;

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the record stream deframer. A scoreboard tracks
// the parser state word by word and checks every result word, field by
// field. Stimulus is a directed opening, then data records under several
// idle and stall mixes, one stream ending of random kind, and a tail of
// words that the stopped parser must ignore.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int ClkPeriod  = 12;
	localparam int HoldCycles = 60;
	localparam int PhaseWords = 80;
	localparam int TailWords  = 20;
	localparam longint LimitNs = 64'd3_000_000;

	typedef enum int {
		END_CLEAN,
		END_MALFORMED,
		END_BADTYPE,
		END_SHORTHDR,
		END_SHORTPAY
	} stream_end_t;

	typedef struct packed {
		logic [brd_pkg::ByteW-1:0] pay;
		logic                      pv;
		brd_pkg::status_t          st;
	} deframe_result_t;

	class deframer_scoreboard;
		brd_pkg::phase_t             phase;
		logic [brd_pkg::HdrIdxW-1:0] hdr_pos;
		logic [brd_pkg::ByteW-1:0]   rec_type;
		logic [brd_pkg::LenW-1:0]    rec_len;
		logic [brd_pkg::LenW-1:0]    left_to_pass;
		brd_pkg::status_t            status;
		deframe_result_t             expected_words[$];
		int                          errors;

		function new();
			phase        = brd_pkg::PH_HEADER;
			hdr_pos      = brd_pkg::HdrType;
			rec_type     = '0;
			rec_len      = '0;
			left_to_pass = '0;
			status       = brd_pkg::ST_RUNNING;
			errors       = 0;
		endfunction

		function void stop_with(brd_pkg::status_t code);
			status = code;
			phase  = brd_pkg::PH_STOPPED;
		endfunction

		function void take_header_byte(logic [brd_pkg::ByteW-1:0] b);
			case (hdr_pos)
				brd_pkg::HdrType:  rec_type = b;
				brd_pkg::HdrLenHi: rec_len[15:8] = b;
				brd_pkg::HdrLenLo: rec_len[7:0] = b;
				default: ;
			endcase
			if (hdr_pos != brd_pkg::HdrLast) begin
				hdr_pos = hdr_pos + brd_pkg::HdrIdxW'(1);
				return;
			end
			hdr_pos = brd_pkg::HdrType;
			if (rec_type == brd_pkg::TypeData) begin
				if (rec_len != '0) begin
					left_to_pass = rec_len;
					phase = brd_pkg::PH_PAYLOAD;
				end
			end else if (rec_type == brd_pkg::TypeEnd) begin
				stop_with(rec_len != '0 ? brd_pkg::ST_MALFORMED : brd_pkg::ST_CLEAN);
			end else begin
				stop_with(brd_pkg::ST_BADTYPE);
			end
		endfunction

		function void note_input_word(logic cmd, logic [brd_pkg::ByteW-1:0] b);
			deframe_result_t r;
			r.pay = '0;
			r.pv  = 1'b0;
			if (phase == brd_pkg::PH_HEADER || phase == brd_pkg::PH_PAYLOAD) begin
				if (cmd == brd_pkg::CmdEnd) begin
					stop_with(phase == brd_pkg::PH_HEADER ? brd_pkg::ST_SHORTHDR
						: brd_pkg::ST_SHORTPAY);
				end else if (phase == brd_pkg::PH_HEADER) begin
					take_header_byte(b);
				end else begin
					r.pay = b;
					r.pv  = 1'b1;
					left_to_pass = left_to_pass - brd_pkg::LenW'(1);
					if (left_to_pass == '0)
						phase = brd_pkg::PH_HEADER;
				end
			end
			r.st = status;
			expected_words.push_back(r);
		endfunction

		function void check_output_word(logic [brd_pkg::ByteW-1:0] pay, logic pv,
			logic [brd_pkg::StatusW-1:0] st);
			deframe_result_t e;
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected result word: payload_byte %h",
					$time, pay, " payload_valid %b parse_status %0d", pv, st);
				errors++;
				return;
			end
			e = expected_words.pop_front();
			if (pay !== e.pay) begin
				$display("%0t: payload_byte mismatch: expected %h, actual %h",
					$time, e.pay, pay);
				errors++;
			end
			if (pv !== e.pv) begin
				$display("%0t: payload_valid mismatch: expected %b, actual %b",
					$time, e.pv, pv);
				errors++;
			end
			if (st !== e.st) begin
				$display("%0t: parse_status mismatch: expected %0d, actual %0d",
					$time, e.st, st);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	brd_in_if  din_if();
	brd_out_if dout_if();

	binary_record_deframer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	deframer_scoreboard sb = new();

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_asked     = 0;
	int hold_granted   = 0;
	int sent_words     = 0;

	always #(ClkPeriod / 2) clk = ~clk;

	initial begin
		#(LimitNs);
		$display("FAILURE");
		$finish;
	end

	initial begin
		dout_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_granted != hold_asked) begin
				dout_if.ready <= 1'b0;
				repeat (HoldCycles - 1) @(posedge clk);
				hold_granted++;
			end else begin
				dout_if.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && dout_if.valid === 1'b1 && dout_if.ready === 1'b1)
			sb.check_output_word(dout_if.payload_byte, dout_if.payload_valid,
				dout_if.parse_status);
	end

	task automatic send_word(input logic cmd, input logic [brd_pkg::ByteW-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			din_if.valid <= 1'b0;
			@(posedge clk);
		end
		din_if.valid     <= 1'b1;
		din_if.command   <= cmd;
		din_if.data_byte <= b;
		do
			@(posedge clk);
		while (din_if.ready !== 1'b1);
		sb.note_input_word(cmd, b);
		sent_words++;
	endtask

	task automatic send_header(input logic [brd_pkg::ByteW-1:0] rtype,
		input logic [brd_pkg::LenW-1:0] len, input logic [brd_pkg::LenW-1:0] addr,
		input int n_bytes);
		logic [brd_pkg::ByteW-1:0] hdr [5];
		hdr[0] = rtype;
		hdr[1] = len[15:8];
		hdr[2] = len[7:0];
		hdr[3] = addr[15:8];
		hdr[4] = addr[7:0];
		for (int i = 0; i < n_bytes; i++)
			send_word(brd_pkg::CmdByte, hdr[i]);
	endtask

	task automatic send_payload(input int n);
		for (int i = 0; i < n; i++)
			send_word(brd_pkg::CmdByte, brd_pkg::ByteW'($urandom_range(0, 255)));
	endtask

	task automatic send_data_record(input logic [brd_pkg::LenW-1:0] len);
		send_header(brd_pkg::TypeData, len, brd_pkg::LenW'($urandom_range(0, 16'hffff)), 5);
		send_payload(int'(len));
	endtask

	task automatic wait_drained();
		din_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input int s_idle, input int r_stall);
		int target;
		int pick;
		send_idle_pct  = s_idle;
		recv_stall_pct = r_stall;
		target = sent_words + PhaseWords;
		while (sent_words < target) begin
			pick = int'($urandom_range(99));
			if (pick < 10)
				send_data_record('0);
			else if (pick < 90)
				send_data_record(brd_pkg::LenW'($urandom_range(1, 8)));
			else
				send_data_record(brd_pkg::LenW'($urandom_range(9, 40)));
		end
		wait_drained();
	endtask

	task automatic end_stream(input stream_end_t kind);
		logic [brd_pkg::LenW-1:0] len;
		case (kind)
			END_CLEAN:
				send_header(brd_pkg::TypeEnd, '0,
					brd_pkg::LenW'($urandom_range(0, 16'hffff)), 5);
			END_MALFORMED:
				send_header(brd_pkg::TypeEnd, brd_pkg::LenW'($urandom_range(1, 16'hffff)),
					brd_pkg::LenW'($urandom_range(0, 16'hffff)), 5);
			END_BADTYPE:
				send_header(brd_pkg::ByteW'($urandom_range(1, 254)),
					brd_pkg::LenW'($urandom_range(0, 16'hffff)),
					brd_pkg::LenW'($urandom_range(0, 16'hffff)), 5);
			END_SHORTHDR: begin
				send_header(brd_pkg::ByteW'($urandom_range(0, 255)),
					brd_pkg::LenW'($urandom_range(0, 16'hffff)),
					brd_pkg::LenW'($urandom_range(0, 16'hffff)),
					int'($urandom_range(0, 4)));
				send_word(brd_pkg::CmdEnd, brd_pkg::ByteW'($urandom_range(0, 255)));
			end
			default: begin
				len = brd_pkg::LenW'($urandom_range(1, 16'hffff));
				send_header(brd_pkg::TypeData, len,
					brd_pkg::LenW'($urandom_range(0, 16'hffff)), 5);
				send_payload(int'($urandom_range(0, (len > 20) ? 20 : int'(len) - 1)));
				send_word(brd_pkg::CmdEnd, brd_pkg::ByteW'($urandom_range(0, 255)));
			end
		endcase
	endtask

	initial begin
		din_if.valid     = 1'b0;
		din_if.command   = brd_pkg::CmdByte;
		din_if.data_byte = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty data record, then short ones with extreme bytes
		send_header(brd_pkg::TypeData, 16'h0000, 16'hffff, 5);
		send_header(brd_pkg::TypeData, 16'h0001, 16'h0000, 5);
		send_word(brd_pkg::CmdByte, 8'hff);
		send_header(brd_pkg::TypeData, 16'h0002, 16'ha55a, 5);
		send_word(brd_pkg::CmdByte, 8'h00);
		send_word(brd_pkg::CmdByte, 8'h80);
		wait_drained();

		// hold the output off while the sender keeps pushing a long record
		hold_asked++;
		send_data_record(brd_pkg::LenW'($urandom_range(256, 300)));
		run_phase(0, 0);
		run_phase(66, 0);
		run_phase(0, 66);
		run_phase(15, 15);

		send_idle_pct  = 15;
		recv_stall_pct = 15;
		end_stream(stream_end_t'($urandom_range(0, 4)));
		for (int i = 0; i < TailWords; i++)
			send_word(($urandom_range(0, 1) != 0) ? brd_pkg::CmdEnd : brd_pkg::CmdByte,
				brd_pkg::ByteW'($urandom_range(0, 255)));
		wait_drained();
		repeat (10) @(posedge clk);

		if (sb.errors == 0 && sb.expected_words.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
